// ===== src/sitp_pkg.sv =====
// Shared types and constants for the signed integer text parser.
// Used by sitp_core, signed_int_text_parser and sitp_checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sitp_pkg;

  typedef enum logic [2:0] {
    PH_DONE   = 3'd0,
    PH_SPACE  = 3'd1,
    PH_SIGN   = 3'd2,
    PH_ZERO   = 3'd3,
    PH_DIGITS = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOTINT = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  // Step outcome handed from the core to the output register
  typedef struct packed {
    logic        emit;
    status_t     status;
    logic [31:0] value;
  } step_out_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_X     = 8'h78;

  // Letters a-f and A-F both carry 1..6 in the low nibble
  localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

  localparam logic [35:0] LIM_NEG = 36'h080000000;
  localparam logic [35:0] LIM_POS = 36'h07FFFFFFF;

  localparam logic REG_MIN = 1'b0;
  localparam logic REG_MAX = 1'b1;

  localparam logic [31:0] MIN_RST = 32'h80000000;
  localparam logic [31:0] MAX_RST = 32'h7FFFFFFF;

endpackage

`default_nettype wire

// ===== src/signed_int_text_parser.sv =====
// Top level of the signed integer text parser: stream ports, APB registers.
// Depends on sitp_pkg and sitp_core.
`timescale 1ns / 1ps
`default_nettype none

// Parses a signed 32-bit decimal or 0x-prefixed hex integer from a stream of
// characters, one character per input word. Set in_tuser on the first
// character of each argument; at most one result word follows per parse,
// carrying the status in out_tuser and the value in out_tdata (zero unless
// the status is ok). The block takes one character per cycle unless a result word
// waits on out_tready; the character that ends the number passes the input
// register, then its result word is loaded into the output register. The rate is
// set by the magnitude register loop, which updates through one shift-add by 10
// or 16 per character. Bounds min_value and max_value are at byte addresses 0 and
// 4 of the APB port; the user must write them only while idle (not enforced).
module signed_int_text_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tuser,   // [0] start_token
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] value
  output logic [1:0]       out_tuser,  // [1:0] status
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import sitp_pkg::*;

  logic        in_v_r;
  logic [7:0]  in_char_r;
  logic        in_start_r;
  logic        out_v_r;
  logic [31:0] out_value_r;
  status_t     out_status_r;
  logic [31:0] min_r, max_r;

  logic        slot_free, step_en, cfg_wr;
  step_out_t   res;

  assign slot_free = !out_v_r || out_tready;
  assign step_en   = in_v_r && slot_free;
  assign in_tready = !in_v_r || slot_free;

  sitp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .char_code  (in_char_r),
    .start_token(in_start_r),
    .min_value  ($signed(min_r)),
    .max_value  ($signed(max_r)),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (step_en) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step_en && res.emit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res.emit) begin
      out_value_r  <= res.value;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  // register select on address bit 2, low bits ignored
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX) ? max_r : min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_RST;
      max_r <= MAX_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_MIN) begin
        min_r <= cfg_pwdata;
      end else begin
        max_r <= cfg_pwdata;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/sitp_core.sv =====
// Parse state and per-character step logic for the signed integer text parser.
// Depends on sitp_pkg for phase, status and result types and character codes.
`timescale 1ns / 1ps
`default_nettype none

module sitp_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire logic [7:0]         char_code,
  input  wire logic               start_token,
  input  wire logic signed [31:0] min_value,
  input  wire logic signed [31:0] max_value,
  output sitp_pkg::step_out_t     res
);
  import sitp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic        hex_r, hex_nxt;
  logic [31:0] mag_r, mag_nxt;

  phase_t      ph_eff;
  logic        neg_eff, hex_eff;
  logic [31:0] mag_eff;

  logic        is_ws, is_dec, is_hex, dig_ok;
  logic [3:0]  dig;
  logic [35:0] acc, lim;
  logic        ovf;
  logic signed [31:0] sval;
  logic        out_of_bounds;

  always_comb begin
    // a start word resets the parse before this character is looked at
    ph_eff  = start_token ? PH_SPACE : phase_r;
    neg_eff = start_token ? 1'b0 : neg_r;
    hex_eff = start_token ? 1'b0 : hex_r;
    mag_eff = start_token ? 32'd0 : mag_r;

    is_ws  = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
    is_dec = (char_code >= CH_0) && (char_code <= CH_9);
    is_hex = hex_eff && (((char_code >= CH_LA) && (char_code <= CH_LF)) ||
                         ((char_code >= CH_UA) && (char_code <= CH_UF)));
    dig_ok = is_dec || is_hex;
    dig    = is_dec ? char_code[3:0] : (char_code[3:0] + HEX_LETTER_OFS);

    // times 16 or times 10 as shift-add
    if (hex_eff) begin
      acc = {mag_eff, 4'b0000} + {32'd0, dig};
    end else begin
      acc = {1'b0, mag_eff, 3'b000} + {3'b000, mag_eff, 1'b0} + {32'd0, dig};
    end
    lim = neg_eff ? LIM_NEG : LIM_POS;
    ovf = acc > lim;

    sval = neg_eff ? $signed(~mag_eff + 32'd1) : $signed(mag_eff);
    out_of_bounds = (sval < min_value) || (sval > max_value);
  end

  always_comb begin
    phase_nxt  = ph_eff;
    neg_nxt    = neg_eff;
    hex_nxt    = hex_eff;
    mag_nxt    = mag_eff;
    res.emit   = 1'b0;
    res.status = ST_OK;
    res.value  = 32'd0;

    unique case (ph_eff)
      PH_SPACE, PH_SIGN: begin
        if (ph_eff == PH_SPACE && is_ws) begin
          phase_nxt = PH_SPACE;
        end else if (char_code == CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_SIGN;
        end else if (char_code == CH_PLUS) begin
          phase_nxt = PH_SIGN;
        end else if (char_code == CH_0) begin
          phase_nxt = PH_ZERO;
        end else if (char_code >= CH_1 && char_code <= CH_9) begin
          if (ovf) begin
            res.emit   = 1'b1;
            res.status = ST_RANGE;
            phase_nxt  = PH_DONE;
          end else begin
            mag_nxt   = acc[31:0];
            phase_nxt = PH_DIGITS;
          end
        end else begin
          res.emit   = 1'b1;
          res.status = ST_NOTINT;
          phase_nxt  = PH_DONE;
        end
      end
      PH_ZERO, PH_DIGITS: begin
        if (ph_eff == PH_ZERO && char_code == CH_X) begin
          hex_nxt   = 1'b1;
          phase_nxt = PH_DIGITS;
        end else if (dig_ok) begin
          if (ovf) begin
            res.emit   = 1'b1;
            res.status = ST_RANGE;
            phase_nxt  = PH_DONE;
          end else begin
            mag_nxt   = acc[31:0];
            phase_nxt = PH_DIGITS;
          end
        end else begin
          // terminator: bounds check and emit
          res.emit  = 1'b1;
          phase_nxt = PH_DONE;
          if (out_of_bounds) begin
            res.status = ST_RANGE;
          end else begin
            res.status = ST_OK;
            res.value  = sval;
          end
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
      neg_r   <= 1'b0;
      hex_r   <= 1'b0;
      mag_r   <= 32'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      hex_r   <= hex_nxt;
      mag_r   <= mag_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/sitp_checker.sv =====
// Port-level assertions for signed_int_text_parser, attached by bind.
// Depends on sitp_pkg for status codes.
`timescale 1ns / 1ps
`default_nettype none

module sitp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        cfg_psel,
  input wire logic        cfg_penable,
  input wire logic        cfg_pwrite,
  input wire logic [2:0]  cfg_paddr,
  input wire logic [31:0] cfg_pwdata,
  input wire logic [31:0] cfg_prdata,
  input wire logic        cfg_pready
);
  import sitp_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // error words carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tdata == 32'd0)
    else $error("nonzero value with error status");

  // input side never stalls while the result side drains
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output ready");

  // a register reads back what was just written
  a_cfg_rb: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) ##1
    (cfg_psel && !cfg_pwrite && (cfg_paddr[2] == $past(cfg_paddr[2])))
    |-> cfg_prdata == $past(cfg_pwdata))
    else $error("register readback mismatch");

endmodule

bind signed_int_text_parser sitp_checker u_sitp_checker (.*);

`default_nettype wire

// ===== bench/signed_int_text_parser_tb.sv =====
// Self-checking bench for signed_int_text_parser: directed and random character streams,
// with an in-bench parser mirror that scores every result word. Depends on sitp_pkg.
`timescale 1ns / 1ps

module signed_int_text_parser_tb;
  import sitp_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int ITEMS_PER_STAGE = 135;
  localparam int NUM_STAGES      = 6;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
  } parse_result_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        start;
    logic        known;
    status_t     status;
    logic [31:0] value;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Parser mirror state and bounds
  phase_t             pm_phase;
  logic               pm_neg;
  logic               pm_hex;
  logic [31:0]        pm_mag;
  logic signed [31:0] bound_lo;
  logic signed [31:0] bound_hi;

  parse_result_t pending_q[$];
  logic [7:0]    arg_text[$];
  int            errors;
  int            n_items;
  int            n_results;
  int            n_ok;
  int            n_notint;
  int            n_range;
  bit            quiet;
  bit            hold_req;

  string hex_digits = "0123456789abcdefABCDEF";
  string corner_args [13] = '{
    "2147483647", "-2147483648", "2147483648", "-2147483649", "0x7fffffff",
    "-0x80000000", "0x80000000", "0xFFFFFFFF", "4294967296",
    "00000000000000000012", "+-+-7", "0", "-0"
  };

  stim_row_t directed [26] = '{
    '{"Q",      1'b0, 1'b1, ST_OK,     32'd0},  // no start since reset: dropped
    '{CH_SPACE, 1'b1, 1'b0, ST_OK,     32'd0},
    '{CH_TAB,   1'b0, 1'b0, ST_OK,     32'd0},
    '{CH_MINUS, 1'b0, 1'b0, ST_OK,     32'd0},
    '{CH_PLUS,  1'b0, 1'b0, ST_OK,     32'd0},
    '{"4",      1'b0, 1'b0, ST_OK,     32'd0},
    '{"2",      1'b0, 1'b0, ST_OK,     32'd0},
    '{8'h00,    1'b0, 1'b1, ST_OK,     -42},
    '{"5",      1'b0, 1'b0, ST_OK,     32'd0},  // done, no start: dropped
    '{CH_PLUS,  1'b1, 1'b0, ST_OK,     32'd0},
    '{"7",      1'b0, 1'b0, ST_OK,     32'd0},
    '{"3",      1'b1, 1'b0, ST_OK,     32'd0},  // restart mid-number
    '{8'hFF,    1'b0, 1'b1, ST_OK,     32'd3},
    '{8'hFF,    1'b1, 1'b1, ST_NOTINT, 32'd0},
    '{CH_MINUS, 1'b1, 1'b0, ST_OK,     32'd0},
    '{CH_SPACE, 1'b0, 1'b1, ST_NOTINT, 32'd0},  // no blank skip after a sign
    '{CH_0,     1'b1, 1'b0, ST_OK,     32'd0},
    '{CH_X,     1'b0, 1'b0, ST_OK,     32'd0},
    '{"g",      1'b0, 1'b1, ST_OK,     32'd0},
    '{CH_0,     1'b1, 1'b0, ST_OK,     32'd0},
    '{"X",      1'b0, 1'b1, ST_OK,     32'd0},  // uppercase X ends the number
    '{CH_0,     1'b1, 1'b0, ST_OK,     32'd0},
    '{CH_X,     1'b0, 1'b0, ST_OK,     32'd0},
    '{CH_UA,    1'b0, 1'b0, ST_OK,     32'd0},
    '{CH_LF,    1'b0, 1'b0, ST_OK,     32'd0},
    '{":",      1'b0, 1'b1, ST_OK,     32'd175}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  signed_int_text_parser u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Digit phase of the mirror: accumulate, or close the number and bound-check it
  function automatic void take_digit(input logic [7:0] c, output logic emit,
                                     output status_t st, output logic [31:0] val);
    logic [4:0]         d;
    logic [35:0]        acc;
    logic signed [33:0] sval;
    logic               ends;
    ends = 1'b0;
    d    = '0;
    emit = 1'b0;
    st   = ST_OK;
    val  = '0;
    if (c >= CH_0 && c <= CH_9) d = 5'(c - CH_0);
    else if (pm_hex && c >= CH_LA && c <= CH_LF) d = 5'(c - CH_LA + 8'd10);
    else if (pm_hex && c >= CH_UA && c <= CH_UF) d = 5'(c - CH_UA + 8'd10);
    else ends = 1'b1;
    if (ends) begin
      sval = pm_neg ? -$signed({2'b00, pm_mag}) : $signed({2'b00, pm_mag});
      emit = 1'b1;
      pm_phase = PH_DONE;
      if (sval < bound_lo || sval > bound_hi) st = ST_RANGE;
      else val = sval[31:0];
    end else begin
      acc = pm_mag * (pm_hex ? 36'd16 : 36'd10) + d;
      if (acc > (pm_neg ? LIM_NEG : LIM_POS)) begin
        emit = 1'b1;
        st = ST_RANGE;
        pm_phase = PH_DONE;
      end else begin
        pm_mag = acc[31:0];
        pm_phase = PH_DIGITS;
      end
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic start, output logic emit,
                                     output status_t st, output logic [31:0] val);
    emit = 1'b0;
    st   = ST_OK;
    val  = '0;
    if (start) begin
      pm_phase = PH_SPACE;
      pm_neg = 1'b0;
      pm_hex = 1'b0;
      pm_mag = '0;
    end
    case (pm_phase)
      PH_SPACE, PH_SIGN: begin
        if (pm_phase == PH_SPACE && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
        end else if (c == CH_MINUS) begin
          pm_neg = 1'b1;
          pm_phase = PH_SIGN;
        end else if (c == CH_PLUS) begin
          pm_phase = PH_SIGN;
        end else if (c == CH_0) begin
          pm_phase = PH_ZERO;
        end else if (c >= CH_1 && c <= CH_9) begin
          take_digit(c, emit, st, val);
        end else begin
          emit = 1'b1;
          st = ST_NOTINT;
          pm_phase = PH_DONE;
        end
      end
      PH_ZERO: begin
        if (c == CH_X) begin
          pm_hex = 1'b1;
          pm_phase = PH_DIGITS;
        end else begin
          take_digit(c, emit, st, val);
        end
      end
      PH_DIGITS: take_digit(c, emit, st, val);
      default: pm_phase = PH_DONE;
    endcase
  endfunction

  // One argument: mostly well-formed numbers, some corner strings, some noise
  function automatic void build_arg();
    string s;
    int    r;
    int    n;
    int    i;
    arg_text.delete();
    r = $urandom_range(99);
    if (r < 12) begin
      s = corner_args[$urandom_range($size(corner_args) - 1)];
      for (i = 0; i < s.len(); i++) arg_text.push_back(s.getc(i));
    end else if (r < 85) begin
      n = $urandom_range(2);
      repeat (n) arg_text.push_back(($urandom_range(4) == 0) ? CH_SPACE :
                                    8'(CH_TAB + $urandom_range(CH_CR - CH_TAB)));
      n = $urandom_range(2);
      repeat (n) arg_text.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
      if ($urandom_range(3) == 0) begin
        arg_text.push_back(CH_0);
        arg_text.push_back(CH_X);
        n = $urandom_range(1, 9);
        repeat (n) arg_text.push_back(hex_digits.getc($urandom_range(hex_digits.len() - 1)));
      end else begin
        n = $urandom_range(1) ? $urandom_range(1, 3) : $urandom_range(1, 11);
        repeat (n) arg_text.push_back(8'(CH_0 + $urandom_range(9)));
      end
    end else begin
      n = $urandom_range(1, 5);
      repeat (n) arg_text.push_back(8'($urandom_range(255)));
    end
    case ($urandom_range(2))
      0: arg_text.push_back(8'h00);
      1: arg_text.push_back(CH_SPACE);
      default: arg_text.push_back(8'($urandom_range(255)));
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic start, output logic emit,
                           output parse_result_t res);
    int gap;
    gap = (quiet || $urandom_range(99) >= 7) ? 0 : $urandom_range(1, 2);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    n_items++;
    parse_char(c, start, emit, res.status, res.value);
    if (emit) pending_q.push_back(res);
  endtask

  // Hold the input off until every pending result is back, then let the core settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_MIN) bound_lo = data;
    else bound_hi = data;
    // read it back
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (cfg_prdata !== data) begin
      errors++;
      $display("%0t: register %0d read back expected %h, got %h", $time, idx, data, cfg_prdata);
    end
  endtask

  // Result side: score each word against the oldest pending result, drive backpressure
  initial begin
    int            hold_left;
    parse_result_t want;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        n_results++;
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got status %0d value %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = pending_q.pop_front();
          if (out_tuser !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_tuser);
          end
          if (out_tdata !== want.value) begin
            errors++;
            $display("%0t: value expected %h, got %h", $time, want.value, out_tdata);
          end
          case (want.status)
            ST_OK:     n_ok++;
            ST_NOTINT: n_notint++;
            default:   n_range++;
          endcase
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || $urandom_range(99) >= 10;
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  initial begin
    int still;
    still = 0;
    while (still < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) still = 0;
      else still++;
    end
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic          emit;
    parse_result_t got;
    logic [31:0]   lo_cfg [NUM_STAGES];
    logic [31:0]   hi_cfg [NUM_STAGES];
    logic [31:0]   swap;
    int            stage;
    int            goal;
    int            i;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_ok = 0;
    n_notint = 0;
    n_range = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    pm_phase = PH_DONE;
    pm_neg = 1'b0;
    pm_hex = 1'b0;
    pm_mag = '0;
    bound_lo = MIN_RST;
    bound_hi = MAX_RST;
    lo_cfg = '{MIN_RST, -1000, MAX_RST, 0, MIN_RST, 0};
    hi_cfg = '{MAX_RST, 1000, MIN_RST, 0, MAX_RST, 0};
    lo_cfg[3] = $urandom;
    hi_cfg[3] = $urandom;
    if ($signed(lo_cfg[3]) > $signed(hi_cfg[3])) begin
      swap = lo_cfg[3];
      lo_cfg[3] = hi_cfg[3];
      hi_cfg[3] = swap;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < $size(directed); i++) begin
      send_char(directed[i].ch, directed[i].start, emit, got);
      if (directed[i].known && i != 0 &&
          (!emit || got.status != directed[i].status || got.value != directed[i].value)) begin
        errors++;
        $display("%0t: row %0d expected status %0d value %h, got status %0d value %h",
                 $time, i, directed[i].status, directed[i].value, got.status, got.value);
      end
      if (directed[i].known && i == 0 && emit) begin
        errors++;
        $display("%0t: row 0 expected no result, got status %0d", $time, got.status);
      end
    end
    drain_results();

    // Stage 1 holds the receiver off, stage 4 runs without gaps on either side
    for (stage = 0; stage < NUM_STAGES; stage++) begin
      if (stage > 0) begin
        reg_write(REG_MIN, lo_cfg[stage]);
        reg_write(REG_MAX, hi_cfg[stage]);
      end
      quiet = (stage == 4);
      hold_req = (stage == 1);
      goal = n_items + ITEMS_PER_STAGE;
      while (n_items < goal) begin
        build_arg();
        for (i = 0; i < arg_text.size(); i++)
          send_char(arg_text[i], (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(39) == 0),
                    emit, got);
      end
      drain_results();
    end

    $display("Parsed %0d characters into %0d results: %0d ok, %0d not an integer,",
             n_items, n_results, n_ok, n_notint);
    $display("%0d out of range, across %0d bound settings including reversed and single-value.",
             n_range, NUM_STAGES);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
